/* design/cnlc_pkg.sv */
// ----------------------------------------------------------------------------
// cnlc_pkg
// shared widths, card type codes and the result record of the card checker
// ----------------------------------------------------------------------------
package cnlc_pkg;

  // card number width and its decimal form
  localparam int IN_W       = 63;
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int BIT_CNT_W  = $clog2(IN_W);
  localparam int DIG_CNT_W  = $clog2(BCD_DIGITS);
  localparam int LEN_W      = 5;

  // most digits examined before the number counts as too long
  localparam int MAX_DIGITS = 19;

  // stream widths, whole bytes
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    CARD_INVALID = 2'd0,
    CARD_AMEX    = 2'd1,
    CARD_MASTER  = 2'd2,
    CARD_VISA    = 2'd3
  } card_type_t;

  typedef struct packed {
    logic [LEN_W-1:0] digit_count;
    logic             checksum_ok;
    card_type_t       card_type;
  } cnlc_result_t;

endpackage

/* design/cnlc_bin2bcd.sv */
// ----------------------------------------------------------------------------
// cnlc_bin2bcd
// bit-serial binary to decimal conversion, one input bit per cycle (shift and add 3)
// ----------------------------------------------------------------------------
module cnlc_bin2bcd (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cnlc_pkg::IN_W-1:0]    bin,
  output logic                         done,
  output logic [cnlc_pkg::BCD_W-1:0]   bcd
);

  logic [cnlc_pkg::IN_W-1:0]      bin_r, bin_nxt;
  logic [cnlc_pkg::BCD_W-1:0]     bcd_r, bcd_nxt, adj;
  logic [cnlc_pkg::BIT_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < cnlc_pkg::BCD_DIGITS; k++) begin
      adj[k*4 +: 4] = (bcd_r[k*4 +: 4] >= 4'd5) ? bcd_r[k*4 +: 4] + 4'd3 : bcd_r[k*4 +: 4];
    end
    bcd_nxt = {adj[cnlc_pkg::BCD_W-2:0], bin_r[cnlc_pkg::IN_W-1]};
    bin_nxt = {bin_r[cnlc_pkg::IN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == cnlc_pkg::BIT_CNT_W'(cnlc_pkg::IN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

/* design/cnlc_digit_scan.sv */
// ----------------------------------------------------------------------------
// cnlc_digit_scan
// walks the decimal digits least significant first, one per cycle: luhn sum,
// length and leading digits, then classification
// ----------------------------------------------------------------------------
module cnlc_digit_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cnlc_pkg::BCD_W-1:0]    bcd,
  output logic                          done,
  output cnlc_pkg::cnlc_result_t        result
);

  logic [cnlc_pkg::BCD_W-1:0]     dig_r;
  logic [cnlc_pkg::DIG_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [3:0]                     sum_r, sum_nxt;
  logic [cnlc_pkg::LEN_W-1:0]     len_r;
  logic [3:0]                     hi_r, lo_r, prev_r;
  logic                           over_r;

  logic [3:0] d;
  logic [4:0] dbl;
  logic [3:0] dd;
  logic [4:0] acc;

  assign d = dig_r[3:0];

  // odd positions are doubled, nine off when above nine
  always_comb begin
    dbl = {d, 1'b0};
    if (cnt_r[0]) begin
      dd = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end else begin
      dd = d;
    end
    acc     = {1'b0, sum_r} + {1'b0, dd};
    sum_nxt = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == cnlc_pkg::DIG_CNT_W'(cnlc_pkg::BCD_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dig_r  <= bcd;
      sum_r  <= '0;
      len_r  <= '0;
      hi_r   <= '0;
      lo_r   <= '0;
      prev_r <= '0;
      over_r <= 1'b0;
    end else if (busy_r) begin
      dig_r  <= {4'd0, dig_r[cnlc_pkg::BCD_W-1:4]};
      sum_r  <= sum_nxt;
      prev_r <= d;
      if (d != 4'd0) begin
        if (cnt_r < cnlc_pkg::DIG_CNT_W'(cnlc_pkg::MAX_DIGITS)) begin
          len_r <= cnlc_pkg::LEN_W'(cnt_r) + 1'b1;
          hi_r  <= d;
          lo_r  <= prev_r;
        end else begin
          over_r <= 1'b1;
        end
      end
    end
  end

  // classification from the final count and leading digit pair
  always_comb begin
    result = '0;
    result.card_type = cnlc_pkg::CARD_INVALID;
    if (over_r) begin
      result.digit_count = cnlc_pkg::LEN_W'(cnlc_pkg::MAX_DIGITS);
      result.checksum_ok = 1'b0;
    end else begin
      result.digit_count = len_r;
      result.checksum_ok = (sum_r == 4'd0);
      if (sum_r == 4'd0) begin
        if (len_r == 5'd15 && hi_r == 4'd3 && (lo_r == 4'd4 || lo_r == 4'd7)) begin
          result.card_type = cnlc_pkg::CARD_AMEX;
        end else if (len_r == 5'd16 && hi_r == 4'd5 && lo_r >= 4'd1 && lo_r <= 4'd5) begin
          result.card_type = cnlc_pkg::CARD_MASTER;
        end else if ((len_r == 5'd13 || len_r == 5'd16) && hi_r == 4'd4) begin
          result.card_type = cnlc_pkg::CARD_VISA;
        end
      end
    end
  end

  assign done = done_r;

endmodule

/* design/card_number_luhn_classify.sv */
// ----------------------------------------------------------------------------
// card_number_luhn_classify
// path: an input transfer starts the conversion, one input bit at a time, then
// the digit walk over the decimal digits, then the handover into the output
// register; the next input is taken once the result has moved into the output
// register, even while it waits for out_tready
// reset: synchronous active-low rst_n clears all control; no clearing pass
// ----------------------------------------------------------------------------
module card_number_luhn_classify (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cnlc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [62:0] pan value, [63] zero
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cnlc_pkg::OUT_TDATA_W-1:0]   out_tdata   // [1:0] card_type, [2] checksum_ok,
                                                         // [7:3] digit_count
);

  logic                          busy_r;       // a card is in conversion, in scan or waiting for the output register
  logic                          pend_r;       // scan result waiting for the output register
  logic                          out_tvalid_r;
  cnlc_pkg::cnlc_result_t        out_res_r;

  logic                          in_xfer;
  logic                          b2b_done;
  logic [cnlc_pkg::BCD_W-1:0]    bcd;
  logic                          scan_done;
  cnlc_pkg::cnlc_result_t        scan_res;
  logic                          load;

  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && in_tready;

  // binary to decimal, one bit per cycle
  cnlc_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .bin   (in_tdata[cnlc_pkg::IN_W-1:0]),
    .done  (b2b_done),
    .bcd   (bcd)
  );

  // digit walk, started as soon as the decimal form is complete
  cnlc_digit_scan u_digit_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (b2b_done),
    .bcd    (bcd),
    .done   (scan_done),
    .result (scan_res)
  );

  // the scan result stays put until the next start, so it can wait in place
  // for a free output register
  assign load = pend_r && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
      end
      if (scan_done) begin
        pend_r <= 1'b1;
      end
      if (load) begin
        pend_r       <= 1'b0;
        busy_r       <= 1'b0;
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= scan_res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_res_r;

  // a card never enters while another is still in conversion or scan
  a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !pend_r && !b2b_done && !scan_done)
    else $error("input transfer while a card is in flight");

  // each conversion finish hands to an idle scan with no result pending
  a_handover_clean: assert property (@(posedge clk) disable iff (!rst_n)
    b2b_done |-> busy_r && !pend_r)
    else $error("conversion finished outside a busy period");

  // a result is only loaded for a card that was accepted
  a_load_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> busy_r)
    else $error("result loaded with no card in flight");

  // a typed card always carries a passing checksum
  a_type_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_res_r.card_type != cnlc_pkg::CARD_INVALID) |-> out_res_r.checksum_ok)
    else $error("card type given with failing checksum");

endmodule
